@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the FIR filter RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/fir_pkg.sv @@
// Shared types and constants of the FIR filter.
// Used by fir_cell, fir_mac and fir_filter; depends on nothing.
package fir_pkg;

  localparam int MAX_TAPS = 128;
  localparam int CNT_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int TIDX_W   = 7;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + CNT_W + 1;

  localparam int TAPC_W   = 8;
  localparam int SHIFT_W  = 5;
  localparam int CFG_W    = 8;
  localparam int CFG_AW   = 1;

  localparam logic [CFG_AW-1:0] REG_TAP_COUNT = 1'd0;
  localparam logic [CFG_AW-1:0] REG_OUT_SHIFT = 1'd1;

  localparam logic [TAPC_W-1:0]  TAP_COUNT_RST = 8'd101;
  localparam logic [SHIFT_W-1:0] OUT_SHIFT_RST = 5'd15;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic term_vld;
    logic round;
  } mac_ctl_t;

endpackage

@@ rtl/core/fir_cell.sv @@
// One tap cell of the FIR ring: a coefficient and one delayed sample.
// Depends on fir_pkg; instantiated in a ring by fir_filter.
module fir_cell import fir_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cell_ctl_t                  ctl,
  input  logic                       coef_we,
  input  logic signed [COEF_W-1:0]   coef_wdata,
  input  logic signed [SAMPLE_W-1:0] shift_data,
  input  logic signed [SAMPLE_W-1:0] rot_hist,
  input  logic signed [COEF_W-1:0]   rot_coef,
  output logic signed [SAMPLE_W-1:0] hist_q,
  output logic signed [COEF_W-1:0]   coef_q
);

  logic signed [SAMPLE_W-1:0] hist_r, hist_nxt;
  logic signed [COEF_W-1:0]   coef_r, coef_nxt;

  always_comb begin
    hist_nxt = hist_r;
    if (ctl.shift) begin
      hist_nxt = shift_data;
    end else if (ctl.rotate) begin
      hist_nxt = rot_hist;
    end
  end

  always_comb begin
    coef_nxt = coef_r;
    if (coef_we) begin
      coef_nxt = coef_wdata;
    end else if (ctl.rotate) begin
      coef_nxt = rot_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
  end

  assign hist_q = hist_r;
  assign coef_q = coef_r;

endmodule

@@ rtl/core/fir_mac.sv @@
// Shared multiply-accumulate, rounding and saturation of the FIR filter.
// Depends on fir_pkg; fed from cell 0 of the ring in fir_filter.
module fir_mac import fir_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic signed [COEF_W-1:0]   coef,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [SHIFT_W-1:0]         out_shift,
  output logic signed [SAMPLE_W-1:0] y,
  output logic                       clip
);

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     prod_vld_r, prod_vld_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  rnd_r, rnd_nxt;
  logic signed [ACC_W-1:0]  bias;
  logic signed [ACC_W-1:0]  shifted;

  assign prod_nxt     = PROD_W'(coef * sample);
  assign prod_vld_nxt = ctl.term_vld;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.start) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  assign bias    = signed'((ACC_W'(1) << out_shift) >> 1);
  assign rnd_nxt = ctl.round ? (acc_r + bias) : rnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= prod_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rnd_r  <= rnd_nxt;
  end

  assign shifted = rnd_r >>> out_shift;

  always_comb begin
    clip = 1'b0;
    y    = shifted[SAMPLE_W-1:0];
    if (shifted > SAT_HI) begin
      clip = 1'b1;
      y    = SAT_HI[SAMPLE_W-1:0];
    end else if (shifted < SAT_LO) begin
      clip = 1'b1;
      y    = SAT_LO[SAMPLE_W-1:0];
    end
  end

endmodule

@@ rtl/core/fir_filter.sv @@
// Top level of the direct-form FIR filter: control, ring of tap cells, MAC.
// Depends on fir_pkg, fir_cell, fir_mac and assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | cmd, tap_index, coef_value, sample_in, frame_start
//   out_    | output    | out_valid / out_stall | sample_out, clipped
//   cfg_    | input     | cfg_we                | cfg_addr, cfg_wdata
//
// A coefficient beat is written in its accepting cycle. A sample beat runs in
// steps: the accepting cycle, then one full lap of the cell ring through the
// shared multiplier, one tap per cycle, then accumulate (S_FLUSH) and round
// (S_DONE), then the result loads into the output register once it is free.
// Reset clears the sample history and control; coefficients are not reset.
// A stalled result holds in the output register while the next beat computes;
// a second result waits in the final state until the first is taken.
`include "assert_macros.svh"

module fir_filter import fir_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [TIDX_W-1:0]          in_tap_index,
  input  logic signed [COEF_W-1:0]   in_coef_value,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_clipped,
  input  logic                       cfg_we,
  input  logic [CFG_AW-1:0]          cfg_addr,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;
  localparam int         CMP_W   = (CNT_W > TAPC_W) ? CNT_W : TAPC_W;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rnd_done_r, rnd_done_nxt;
  logic [TAPC_W-1:0]  tap_count_r, tap_count_nxt;
  logic [SHIFT_W-1:0] out_shift_r, out_shift_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic               out_clipped_r, out_clipped_nxt;

  logic in_accept, coef_load, sample_take, out_free, cnt_last, tap_active;
  cell_ctl_t cell_ctl;
  mac_ctl_t  mac_ctl;

  logic signed [SAMPLE_W-1:0] hist_q [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_q [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] mac_y;
  logic                       mac_clip;

  assign in_stall    = (state_r != S_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign coef_load   = in_accept && (in_cmd == CMD_LOAD);
  assign sample_take = in_accept && (in_cmd == CMD_SAMPLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign cnt_last    = (cnt_r == CNT_W'(MAX_TAPS - 1));
  assign tap_active  = (CMP_W'(cnt_r) < CMP_W'(tap_count_r));

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rnd_done_nxt = rnd_done_r;
    unique case (state_r)
      S_IDLE: begin
        if (sample_take) begin
          state_nxt = S_RUN;
          cnt_nxt   = '0;
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = S_FLUSH;
          cnt_nxt   = '0;
        end
      end
      S_FLUSH: begin
        state_nxt    = S_DONE;
        rnd_done_nxt = 1'b0;
      end
      S_DONE: begin
        rnd_done_nxt = 1'b1;
        if (rnd_done_r && out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cell_ctl.shift  = sample_take;
    cell_ctl.rotate = (state_r == S_RUN);
    mac_ctl.start    = sample_take;
    mac_ctl.term_vld = (state_r == S_RUN) && tap_active;
    mac_ctl.round    = (state_r == S_DONE) && !rnd_done_r;
  end

  always_comb begin
    tap_count_nxt = tap_count_r;
    out_shift_nxt = out_shift_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_TAP_COUNT: tap_count_nxt = cfg_wdata[TAPC_W-1:0];
        REG_OUT_SHIFT: out_shift_nxt = cfg_wdata[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r && out_stall;
    out_sample_nxt  = out_sample_r;
    out_clipped_nxt = out_clipped_r;
    if ((state_r == S_DONE) && rnd_done_r && out_free) begin
      out_valid_nxt   = 1'b1;
      out_sample_nxt  = mac_y;
      out_clipped_nxt = mac_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rnd_done_r  <= 1'b0;
      tap_count_r <= TAP_COUNT_RST;
      out_shift_r <= OUT_SHIFT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rnd_done_r  <= rnd_done_nxt;
      tap_count_r <= tap_count_nxt;
      out_shift_r <= out_shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r  <= out_sample_nxt;
    out_clipped_r <= out_clipped_nxt;
  end

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    localparam int NXT = (k + 1) % MAX_TAPS;
    logic signed [SAMPLE_W-1:0] shift_data;
    logic                       coef_we;

    if (k == 0) begin : g_head
      assign shift_data = in_sample_in;
    end else begin : g_body
      assign shift_data = in_frame_start ? '0 : hist_q[k-1];
    end

    assign coef_we = coef_load && (32'(in_tap_index) == k);

    fir_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .coef_we    (coef_we),
      .coef_wdata (in_coef_value),
      .shift_data (shift_data),
      .rot_hist   (hist_q[NXT]),
      .rot_coef   (coef_q[NXT]),
      .hist_q     (hist_q[k]),
      .coef_q     (coef_q[k])
    );
  end

  fir_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .coef      (coef_q[0]),
    .sample    (hist_q[0]),
    .out_shift (out_shift_r),
    .y         (mac_y),
    .clip      (mac_clip)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

  `ASSERT_IMPL(a_cnt_idle, state_r != S_RUN, cnt_r == '0)
  `ASSERT_NEXT(a_take_runs, sample_take, state_r == S_RUN && cnt_r == '0)
  `ASSERT_NEXT(a_lap_ends, state_r == S_RUN && cnt_last, state_r == S_FLUSH)
  `ASSERT_IMPL(a_out_from_done, $rose(out_valid_r), $past(state_r) == S_DONE)

endmodule
